// ===== rtl/tqla_pkg.sv =====
// Package with the op codes, register indexes and fixed constants of the Q-learning agent.
`timescale 1ns / 1ps
package tqla_pkg;

  typedef enum logic [1:0] {
    OP_CHOOSE = 2'd0,
    OP_RECORD = 2'd1,
    OP_START  = 2'd2,
    OP_DECAY  = 2'd3
  } op_t;

  localparam int CfgIdxWidth = 2;
  localparam int RateWidth   = 16;

  localparam logic [CfgIdxWidth-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_DISCOUNT      = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_EPSILON_START = 2'd2;

  localparam logic [RateWidth-1:0] LR_RESET    = 16'd6554;
  localparam logic [RateWidth-1:0] GAMMA_RESET = 16'd62259;
  localparam logic [RateWidth-1:0] EPS_RESET   = 16'd1311;
  localparam logic [RateWidth-1:0] EPS_FLOOR   = 16'd1311;
  localparam logic [RateWidth-1:0] EPS_DECAY   = 16'd65208;

  localparam int RewardWidth = 24;
  localparam int NumActions  = 4;

endpackage

// ===== rtl/tabular_q_learning_agent_top.sv =====
// Tabular Q-learning agent with epsilon-greedy choice, built around one row memory.
//
// Requests enter on in_valid/in_stall and results leave on out_valid/out_stall;
// a request is taken when valid is high and stall is low. Each request gives
// exactly one result. Configuration is written through cfg_write/cfg_index/cfg_data.
// Each memory row holds the four Q values of one state and its seen bit, and the
// memory has one registered read port and one write port. The output register
// loads in S_FIN once it is empty or not stalled. Start episode, decay and a
// record with no stored pair go to S_FIN straight from S_IDLE; choose passes
// S_ROWA first, and a record that updates passes S_ROWA, S_ROWB, S_MUL1, S_MUL2,
// S_WRS and S_WRP (two row reads, two multiplies in series, two row writes).
// The next request is taken once the block is back in S_IDLE after the load.
// One request is worked on at a time. While the receiver stalls, one result
// waits in the output register and one more request can be taken and finished
// behind it; after that in_stall stays high. After reset the block sweeps the
// memory to zero, one row per cycle, over all 2**STATE_BITS rows, and takes no
// request meanwhile; configuration writes are taken at all times. Reset also
// restores the rates and epsilon to defaults and forgets the stored state/action pair.
`timescale 1ns / 1ps
module tabular_q_learning_agent_top
  import tqla_pkg::*;
#(
  parameter int STATE_BITS = 9,
  parameter int QVAL_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CfgIdxWidth-1:0]        cfg_index,
  input  logic [RateWidth-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [2:0]                    danger_bits,
  input  logic [1:0]                    heading,
  input  logic [3:0]                    food_bits,
  input  logic [1:0]                    taken_action,
  input  logic signed [RewardWidth-1:0] reward,
  input  logic                          training,
  input  logic [RateWidth-1:0]          random_draw,
  input  logic [1:0]                    random_action,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    chosen_action,
  output logic                          explored,
  output logic                          unseen_state,
  output logic [RateWidth-1:0]          epsilon_now
);

  localparam int Rows  = 1 << STATE_BITS;
  localparam int QW    = QVAL_WIDTH;
  localparam int RowW  = NumActions * QW + 1;
  localparam int DW    = ((QW > RewardWidth) ? QW : RewardWidth) + 3;
  localparam int GPW   = QW + RateWidth + 1;
  localparam int DPW   = DW + RateWidth + 1;
  localparam int SW    = DW + 2;
  localparam logic signed [SW-1:0] QMAX = SW'((64'sd1 <<< (QW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] QMIN = -QMAX - SW'(1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ROWA  = 9'b000000100,
    S_ROWB  = 9'b000001000,
    S_MUL1  = 9'b000010000,
    S_MUL2  = 9'b000100000,
    S_WRS   = 9'b001000000,
    S_WRP   = 9'b010000000,
    S_FIN   = 9'b100000000
  } st_t;

  st_t state, state_next;

  logic [RowW-1:0] mem [Rows];
  logic [RowW-1:0] rd_data;
  logic [STATE_BITS-1:0] rd_addr, wr_addr, clr_cnt;
  logic [RowW-1:0] wr_data;
  logic wr_en;

  logic [RateWidth-1:0] learning_rate, discount, epsilon_level;
  logic [STATE_BITS-1:0] prev_state;
  logic [1:0] prev_action;
  logic prev_valid;

  // Request fields held while the request is worked on.
  logic [STATE_BITS-1:0] s_r;
  logic [1:0] act_r, ract_r;
  op_t op_r;
  logic signed [RewardWidth-1:0] reward_r;
  logic training_r;
  logic [RateWidth-1:0] draw_r;

  logic [RowW-1:0] row_s, row_p;
  logic signed [QW-1:0] mx, cur, qnew;
  logic signed [GPW-1:0] g_prod;
  logic signed [DW-1:0] d;
  logic signed [DPW-1:0] d_prod;

  logic [1:0] res_action;
  logic res_explored, res_unseen;

  logic accept;
  logic [STATE_BITS-1:0] in_s;
  logic [8:0] full_idx;
  logic signed [QW-1:0] rd_q [NumActions];
  logic signed [QW-1:0] rd_max;
  logic [1:0] rd_arg;
  logic [2*RateWidth-1:0] eps_prod;
  logic [RateWidth-1:0] eps_dec;
  logic signed [SW-1:0] sum;
  logic [RowW-1:0] row_p_upd;

  assign full_idx = {danger_bits, heading, food_bits};
  assign in_s     = STATE_BITS'(full_idx);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign eps_prod = epsilon_level * EPS_DECAY;
  assign eps_dec  = (eps_prod[2*RateWidth-1:RateWidth] < EPS_FLOOR) ?
                    EPS_FLOOR : eps_prod[2*RateWidth-1:RateWidth];

  // Row maximum and its first position over the freshly read row.
  always_comb begin
    for (int a = 0; a < NumActions; a++) begin
      rd_q[a] = rd_data[a*QW +: QW];
    end
    rd_max = rd_q[0];
    rd_arg = 2'd0;
    for (int a = 1; a < NumActions; a++) begin
      if (rd_q[a] > rd_max) begin
        rd_max = rd_q[a];
        rd_arg = 2'(a);
      end
    end
  end

  assign sum = SW'(cur) + SW'(d_prod >>> RateWidth);

  always_comb begin
    row_p_upd = {1'b1, row_p[RowW-2:0]};
    for (int a = 0; a < NumActions; a++) begin
      if (prev_action == 2'(a)) begin
        row_p_upd[a*QW +: QW] = qnew;
      end
    end
  end

  always_comb begin
    rd_addr = s_r;
    case (state)
      S_IDLE:  rd_addr = in_s;
      S_ROWA:  rd_addr = prev_state;
      default: rd_addr = s_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s_r;
    wr_data = row_s;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
      end
      S_WRS: begin
        wr_en   = 1'b1;
        wr_addr = s_r;
        wr_data = {1'b1, row_s[RowW-2:0]};
      end
      S_WRP: begin
        wr_en   = 1'b1;
        wr_addr = prev_state;
        wr_data = row_p_upd;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == STATE_BITS'(Rows - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (op == OP_CHOOSE || (op == OP_RECORD && prev_valid)) begin
            state_next = S_ROWA;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_ROWA:  state_next = (op_r == OP_CHOOSE) ? S_FIN : S_ROWB;
      S_ROWB:  state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_WRS;
      S_WRS:   state_next = S_WRP;
      S_WRP:   state_next = S_FIN;
      S_FIN:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      learning_rate <= LR_RESET;
      discount      <= GAMMA_RESET;
      epsilon_level <= EPS_RESET;
      prev_state    <= '0;
      prev_action   <= '0;
      prev_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + STATE_BITS'(1);
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_LEARNING_RATE: learning_rate <= cfg_data;
          REG_DISCOUNT:      discount <= cfg_data;
          REG_EPSILON_START: epsilon_level <= cfg_data;
          default:           ;
        endcase
      end
      if (accept) begin
        case (op_t'(op))
          OP_RECORD: begin
            if (!prev_valid) begin
              prev_state  <= in_s;
              prev_action <= taken_action;
              prev_valid  <= 1'b1;
            end
          end
          OP_START: prev_valid <= 1'b0;
          OP_DECAY: epsilon_level <= eps_dec;
          default:  ;
        endcase
      end
      if (state == S_WRP) begin
        prev_state  <= s_r;
        prev_action <= act_r;
        prev_valid  <= 1'b1;
      end
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_r          <= in_s;
      act_r        <= taken_action;
      ract_r       <= random_action;
      op_r         <= op_t'(op);
      reward_r     <= reward;
      training_r   <= training;
      draw_r       <= random_draw;
      res_action   <= 2'd0;
      res_explored <= 1'b0;
      res_unseen   <= 1'b0;
    end
    if (state == S_ROWA) begin
      row_s <= rd_data;
      mx    <= rd_max;
      if (op_r == OP_CHOOSE) begin
        res_unseen <= !rd_data[RowW-1];
        if (training_r && draw_r < epsilon_level) begin
          res_action   <= ract_r;
          res_explored <= 1'b1;
        end else if (!rd_data[RowW-1]) begin
          res_action <= ract_r;
        end else begin
          res_action <= rd_arg;
        end
      end
    end
    if (state == S_ROWB) begin
      row_p  <= rd_data;
      cur    <= rd_data[prev_action*QW +: QW];
      g_prod <= mx * $signed({1'b0, discount});
    end
    if (state == S_MUL1) begin
      d <= DW'(reward_r) + DW'(g_prod >>> RateWidth) - DW'(cur);
    end
    if (state == S_MUL2) begin
      d_prod <= d * $signed({1'b0, learning_rate});
    end
    if (state == S_WRS) begin
      if (sum > QMAX) begin
        qnew <= QW'(QMAX);
      end else if (sum < QMIN) begin
        qnew <= QW'(QMIN);
      end else begin
        qnew <= QW'(sum);
      end
    end
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      chosen_action <= res_action;
      explored      <= res_explored;
      unseen_state  <= res_unseen;
      epsilon_now   <= epsilon_level;
    end
  end

`ifndef SYNTHESIS
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || state == S_WRS || state == S_WRP))
    else $error("memory written outside clear or write-back");
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second request taken while one is in progress");
  a_eps_floor: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_DECAY && !cfg_write) |=> (epsilon_level >= EPS_FLOOR))
    else $error("epsilon decayed below its floor");
  a_explore_choose: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROWA && op_r != OP_CHOOSE) |=> !res_explored)
    else $error("exploration flagged for a request other than choose");
`endif

endmodule
